/* sv/assert_macros.svh */
// Assertion helpers shared by the scanner RTL.
// Both expect a signal named clk in the enclosing module; CFS_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cfs_pkg.sv */
package cfs_pkg;

    localparam int POSITION_BITS = 24;
    localparam int POS_OUT_BITS  = 24;
    localparam int SYMBOL_BITS   = 8;
    localparam int CODON_BITS    = 3 * SYMBOL_BITS;
    localparam int SEQ_LEN_BITS  = 24;
    localparam int CFG_INDEX_BITS = 1;

    // compare width for reverse position, sum width for forward position
    localparam int CMP_W  = (POSITION_BITS > SEQ_LEN_BITS) ? POSITION_BITS : SEQ_LEN_BITS;
    localparam int CALC_W = (POSITION_BITS + 1 > POS_OUT_BITS + 1) ?
                            POSITION_BITS + 1 : POS_OUT_BITS + 1;

    localparam logic [POS_OUT_BITS-1:0] POS_MAX = {POS_OUT_BITS{1'b1}};

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION       = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEQUENCE_LENGTH = 1'b1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STOP  = 1'b1;

    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_REVERSE = 1'b1;

    localparam logic [CODON_BITS-1:0] CODON_START_FWD = 24'h415447; // ATG
    localparam logic [CODON_BITS-1:0] CODON_STOP_F1   = 24'h544141; // TAA
    localparam logic [CODON_BITS-1:0] CODON_STOP_F2   = 24'h544741; // TGA
    localparam logic [CODON_BITS-1:0] CODON_STOP_F3   = 24'h544147; // TAG
    localparam logic [CODON_BITS-1:0] CODON_START_REV = 24'h544143; // TAC
    localparam logic [CODON_BITS-1:0] CODON_STOP_R1   = 24'h415454; // ATT
    localparam logic [CODON_BITS-1:0] CODON_STOP_R2   = 24'h414354; // ACT
    localparam logic [CODON_BITS-1:0] CODON_STOP_R3   = 24'h415443; // ATC

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   restart;
    } in_item_t;

    typedef struct packed {
        logic                    event_kind;
        logic [POS_OUT_BITS-1:0] position;
        logic [CODON_BITS-1:0]   codon;
    } out_item_t;

    typedef struct packed {
        logic                    direction;
        logic [SEQ_LEN_BITS-1:0] sequence_length;
    } cfg_t;

endpackage

/* sv/cfs_cfg_regs.sv */
module cfs_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [cfs_pkg::SEQ_LEN_BITS-1:0]     cfg_data,
    output cfs_pkg::cfg_t                        cfg
);
    import cfs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DIRECTION:       cfg_next.direction       = cfg_data[0];
                CFG_SEQUENCE_LENGTH: cfg_next.sequence_length = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/cfs_core.sv */
`include "assert_macros.svh"

module cfs_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  cfs_pkg::in_item_t  item,
    input  cfs_pkg::cfg_t      cfg,
    output logic               res_valid,
    output cfs_pkg::out_item_t res_item
);
    import cfs_pkg::*;

    logic [CODON_BITS-1:0]    window_reg,   window_next;
    logic [1:0]               phase_reg,    phase_next;
    logic                     in_frame_reg, in_frame_next;
    logic [POSITION_BITS-1:0] count_reg,    count_next;

    // state as seen after an optional restart
    logic [CODON_BITS-1:0]    window_cur;
    logic [1:0]               phase_cur;
    logic                     in_frame_cur;
    logic [POSITION_BITS-1:0] count_cur;

    logic                     rev;
    logic [CALC_W-1:0]        fwd_sum;
    logic [CMP_W-1:0]         rev_diff;
    logic [POS_OUT_BITS-1:0]  pos;
    logic [CODON_BITS-1:0]    win_new;
    logic [1:0]               phase_inc;
    logic                     is_start;
    logic                     is_stop;

    always_comb
    begin
        window_cur   = item.restart ? '0 : window_reg;
        phase_cur    = item.restart ? 2'd0 : phase_reg;
        in_frame_cur = item.restart ? 1'b0 : in_frame_reg;
        count_cur    = item.restart ? '0 : count_reg;
        rev          = (cfg.direction == DIR_REVERSE);

        fwd_sum  = CALC_W'(count_cur) + CALC_W'(1);
        rev_diff = CMP_W'(cfg.sequence_length) - CMP_W'(count_cur);
        if (rev)
        begin
            pos = (CMP_W'(count_cur) < CMP_W'(cfg.sequence_length)) ?
                  rev_diff[POS_OUT_BITS-1:0] : '0;
        end
        else
        begin
            pos = (fwd_sum > CALC_W'(POS_MAX)) ? POS_MAX : fwd_sum[POS_OUT_BITS-1:0];
        end

        win_new = {window_cur[CODON_BITS-SYMBOL_BITS-1:0], item.symbol};

        is_start = rev ? (win_new == CODON_START_REV) : (win_new == CODON_START_FWD);
        if (rev)
        begin
            is_stop = (win_new == CODON_STOP_R1) || (win_new == CODON_STOP_R2) ||
                      (win_new == CODON_STOP_R3);
        end
        else
        begin
            is_stop = (win_new == CODON_STOP_F1) || (win_new == CODON_STOP_F2) ||
                      (win_new == CODON_STOP_F3);
        end

        phase_inc     = phase_cur + 2'd1;
        window_next   = win_new;
        count_next    = (count_cur != {POSITION_BITS{1'b1}}) ? count_cur + 1'b1 : count_cur;
        phase_next    = phase_cur;
        in_frame_next = in_frame_cur;
        res_valid     = 1'b0;
        res_item.event_kind = KIND_START;

        if (!in_frame_cur)
        begin
            if (is_start)
            begin
                in_frame_next = 1'b1;
                phase_next    = 2'd0;
                res_valid     = 1'b1;
            end
        end
        else
        begin
            phase_next = phase_inc;
            if (phase_inc == 2'd3)
            begin
                phase_next = 2'd0;
                if (is_stop)
                begin
                    in_frame_next       = 1'b0;
                    res_valid           = 1'b1;
                    res_item.event_kind = KIND_STOP;
                end
            end
        end

        res_valid         = res_valid & step;
        res_item.position = pos;
        res_item.codon    = win_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            phase_reg    <= 2'd0;
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end
        else if (step)
        begin
            window_reg   <= window_next;
            phase_reg    <= phase_next;
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

    `CFS_ASSERT_ALWAYS(a_phase_range, !rst_n || phase_reg != 2'd3, "frame phase reached 3")
    `CFS_ASSERT(a_phase_idle, !in_frame_reg |-> phase_reg == 2'd0,
        "frame phase moved while searching")
    `CFS_ASSERT(a_start_sets_frame,
        res_valid && res_item.event_kind == KIND_START |=> in_frame_reg,
        "start reported without entering frame")
    `CFS_ASSERT(a_stop_clears_frame,
        res_valid && res_item.event_kind == KIND_STOP |=> !in_frame_reg,
        "stop reported but frame still open")

endmodule

/* sv/cfs_out_reg.sv */
`include "assert_macros.svh"

module cfs_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               res_valid,
    input  cfs_pkg::out_item_t res_item,
    input  logic               out_stall,
    output logic               out_valid,
    output cfs_pkg::out_item_t out_item
);
    import cfs_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg,  item_next;

    // load only happens when the register is free or draining this cycle
    always_comb
    begin
        valid_next = valid_reg & out_stall;
        item_next  = item_reg;
        if (load)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                item_next = res_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    `CFS_ASSERT(a_load_free, load |-> !(valid_reg && out_stall),
        "result register overwritten while stalled")
    `CFS_ASSERT(a_load_shows, load && res_valid |=> out_valid,
        "loaded result not presented")

endmodule

/* sv/codon_frame_scanner.sv */
// Codon frame scanner: finds start and stop codons in a stream of ASCII
// nucleotide bytes, one symbol per input beat.
// Input channel: in_valid / in_stall carrying in_item (symbol, restart).
//   A beat is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall carrying out_item (event_kind,
//   position, codon). Zero or one result beat per input beat, in order.
// Config channel: cfg_valid / cfg_ready, cfg_index 0 = direction,
//   1 = sequence_length. cfg_ready is always high; write only when idle.
// Pipeline: a taken input beat loads the input register; the result register
//   loads from it when the symbol advances (result register not blocked),
//   and the result then shows on out_item.
// Throughput: one symbol per cycle while the result register is not blocked;
//   the per-symbol compare and shift sits between input and result registers.
// Stall: when the result register holds a beat and out_stall is high, the
//   input register cannot drain and in_stall rises while it holds a symbol.
//   Symbols that produce no result still need the result stage free.
// Reset (rst_n low, async): window, frame, position count, config and all
//   valid flags cleared; direction forward, sequence_length zero.
`include "assert_macros.svh"

module codon_frame_scanner (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  cfs_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output cfs_pkg::out_item_t                 out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cfs_pkg::SEQ_LEN_BITS-1:0]   cfg_data
);
    import cfs_pkg::*;

    cfg_t      cfg;

    // input register
    logic      stage_valid_reg, stage_valid_next;
    in_item_t  stage_reg,       stage_next;

    logic      out_blocked;
    logic      advance;
    logic      res_valid;
    out_item_t res_item;

    assign out_blocked = out_valid & out_stall;
    assign advance     = stage_valid_reg & ~out_blocked;
    assign in_stall    = stage_valid_reg & out_blocked;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (!in_stall)
        begin
            stage_valid_next = in_valid;
            if (in_valid)
            begin
                stage_next = in_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    cfs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cfs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (stage_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    cfs_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res_item  (res_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    `CFS_ASSERT(a_stall_cause, in_stall |-> stage_valid_reg && out_valid && out_stall,
        "input stalled without a blocked result")
    `CFS_ASSERT(a_stall_holds, in_stall |=> stage_valid_reg,
        "stalled symbol dropped from input register")

endmodule
